@@ rtl/pffe_pkg.sv @@
// shared types, widths and constants of the particle force field evaluator
// depends on nothing; every other file but pffe_div_pipe imports it
package pffe_pkg;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int MAG_W   = 31;
  localparam int DIFF_W  = 33;
  localparam int SQ_W    = 66;
  localparam int ROOT_W  = 33;
  localparam int UNIT_W  = 18;
  localparam int FORCE_W = 33;
  localparam int QUO_W   = 31;
  localparam int ADDR_W  = 5;

  localparam logic [16:0] ONE_Q = 17'h10000;
  localparam logic signed [DATA_W-1:0] I32_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] I32_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    SHAPE_ATTRACTOR = 2'd0,
    SHAPE_BASIN     = 2'd1,
    SHAPE_LINEAR    = 2'd2,
    SHAPE_RADIAL    = 2'd3
  } shape_t;

  typedef enum logic [1:0] {
    FT_FORCE   = 2'd0,
    FT_GRAVITY = 2'd1,
    FT_OFFSET  = 2'd2
  } force_type_t;

  typedef enum logic [2:0] {
    REG_SHAPE      = 3'd0,
    REG_FORCE_TYPE = 3'd1,
    REG_ORIGIN_X   = 3'd2,
    REG_ORIGIN_Y   = 3'd3,
    REG_RADIUS     = 3'd4,
    REG_PULL       = 3'd5,
    REG_LINEAR_X   = 3'd6,
    REG_LINEAR_Y   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    shape_t             shape;
    logic [DATA_W-1:0]  pull;
    logic [DATA_W-1:0]  linear_x;
    logic [DATA_W-1:0]  linear_y;
  } shape_cfg_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [47:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 48'(I32_MAX)) begin
      r = I32_MAX;
    end else if (v < 48'(I32_MIN)) begin
      r = I32_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/pffe_sqrt_pipe.sv @@
// pipelined floor square root of a 66-bit value, one result bit per stage
// depends on pffe_pkg for the widths
module pffe_sqrt_pipe
  import pffe_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [SQ_W-1:0]   rad,
  input  logic [SIDE_W-1:0] side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] root,
  output logic [SIDE_W-1:0] side_o
);

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_r  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_r [0:ROOT_W-1];
  logic [SQ_W-1:0]   rad_r  [0:ROOT_W-1];
  logic [SIDE_W-1:0] side_r [0:ROOT_W-1];
  logic              vld_r  [0:ROOT_W-1];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int I = ROOT_W - 1 - s;
    logic [REM_W-1:0]  rem_c;
    logic [REM_W-1:0]  rem_cat;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] root_c;
    logic [SQ_W-1:0]   rad_c;
    logic [SIDE_W-1:0] side_c;
    logic              vld_c;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_c  = '0;
      assign root_c = '0;
      assign rad_c  = rad;
      assign side_c = side;
      assign vld_c  = in_vld;
    end else begin : g_next
      assign rem_c  = rem_r[s-1];
      assign root_c = root_r[s-1];
      assign rad_c  = rad_r[s-1];
      assign side_c = side_r[s-1];
      assign vld_c  = vld_r[s-1];
    end

    // bring down the next bit pair, try (root << 2) | 1
    assign rem_cat = {rem_c[REM_W-3:0], rad_c[2*I +: 2]};
    assign trial   = {1'b0, root_c, 2'b01};
    assign ge      = (rem_cat >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? (rem_cat - trial) : rem_cat;
        root_r[s] <= {root_c[ROOT_W-2:0], ge};
        rad_r[s]  <= rad_c;
        side_r[s] <= side_c;
      end
    end
  end

  assign out_vld = vld_r[ROOT_W-1];
  assign root    = root_r[ROOT_W-1];
  assign side_o  = side_r[ROOT_W-1];

endmodule

@@ rtl/pffe_div_pipe.sv @@
// pipelined restoring divider: quotient bits MSB first, one bit per stage,
// with an overflow flag when the quotient reaches 2^Q_W; no package needed
module pffe_div_pipe #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 33,
  parameter int Q_W    = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_vld,
  output logic [Q_W-1:0]    quo,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_o
);

  localparam int X_W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

  logic [X_W-1:0]    rem_r  [0:Q_W];
  logic [DEN_W-1:0]  den_r  [0:Q_W];
  logic [Q_W-1:0]    quo_r  [0:Q_W];
  logic              ovf_r  [0:Q_W];
  logic [SIDE_W-1:0] side_r [0:Q_W];
  logic              vld_r  [0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= X_W'(num);
      den_r[0]  <= den;
      quo_r[0]  <= '0;
      ovf_r[0]  <= (X_W'(num) >= (X_W'(den) << Q_W));
      side_r[0] <= side;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic [X_W-1:0] shifted;
    logic           ge;

    assign shifted = X_W'(den_r[k]) << B;
    assign ge      = (rem_r[k] >= shifted);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? (rem_r[k] - shifted) : rem_r[k];
        den_r[k+1]  <= den_r[k];
        quo_r[k+1]  <= {quo_r[k][Q_W-2:0], ge};
        ovf_r[k+1]  <= ovf_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_vld = vld_r[Q_W];
  assign quo     = quo_r[Q_W];
  assign ovf     = ovf_r[Q_W];
  assign side_o  = side_r[Q_W];

endmodule

@@ rtl/pffe_shape.sv @@
// force shape stages: falloff weights, magnitude and projection on the
// unit direction, five register stages; depends on pffe_pkg
module pffe_shape
  import pffe_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic signed [UNIT_W-1:0]  ux,
  input  logic signed [UNIT_W-1:0]  uy,
  input  logic [QUO_W-1:0]          t,
  input  shape_cfg_t                cfg,
  input  logic [SIDE_W-1:0]         side,
  output logic                      out_vld,
  output logic signed [FORCE_W-1:0] fx,
  output logic signed [FORCE_W-1:0] fy,
  output logic [SIDE_W-1:0]         side_o
);

  logic [4:0] vld;

  // stage 1
  logic signed [UNIT_W-1:0] ux1, uy1;
  logic                     att1;
  logic [33:0]              ww1;
  logic [61:0]              tt1;
  logic [SIDE_W-1:0]        side1;
  // stage 2
  logic signed [UNIT_W-1:0] ux2, uy2;
  logic                     att2;
  logic signed [49:0]       p1;
  logic signed [63:0]       p2;
  logic [SIDE_W-1:0]        side2;
  // stage 3
  logic signed [UNIT_W-1:0] ux3, uy3;
  logic signed [FORCE_W-1:0] s3;
  logic [SIDE_W-1:0]        side3;
  // stage 4
  logic signed [50:0]       px4, py4;
  logic [SIDE_W-1:0]        side4;

  logic                     att_c;
  logic [16:0]              w_c;
  logic [16:0]              wq_c;
  logic [QUO_W-1:0]         t2_c;
  logic signed [49:0]       sa_full;
  logic signed [63:0]       sb_full;
  logic signed [DATA_W-1:0] sb_c;
  logic signed [FORCE_W-1:0] s_c;
  logic signed [50:0]       fxs, fys;

  assign att_c = (t <= QUO_W'(ONE_Q));
  assign w_c   = ONE_Q - t[16:0];

  assign wq_c  = ww1[32:16];
  assign t2_c  = (|tt1[61:47]) ? QUO_W'(I32_MAX) : tt1[46:16];

  assign sa_full = p1 >>> FRAC_W;
  assign sb_full = p2 >>> FRAC_W;
  assign sb_c    = sat32(sb_full[47:0]);

  always_comb begin
    case (cfg.shape)
      SHAPE_ATTRACTOR: s_c = att2 ? sa_full[FORCE_W-1:0] : '0;
      SHAPE_BASIN:     s_c = FORCE_W'(sb_c);
      default:         s_c = FORCE_W'($signed(cfg.pull));
    endcase
  end

  assign fxs = px4 >>> FRAC_W;
  assign fys = py4 >>> FRAC_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux1   <= ux;
      uy1   <= uy;
      att1  <= att_c;
      ww1   <= 34'(w_c) * 34'(w_c);
      tt1   <= 62'(t) * 62'(t);
      side1 <= side;

      ux2   <= ux1;
      uy2   <= uy1;
      att2  <= att1;
      p1    <= $signed({1'b0, wq_c}) * $signed(cfg.pull);
      p2    <= $signed({1'b0, t2_c}) * $signed(cfg.pull);
      side2 <= side1;

      ux3   <= ux2;
      uy3   <= uy2;
      s3    <= s_c;
      side3 <= side2;

      px4   <= ux3 * s3;
      py4   <= uy3 * s3;
      side4 <= side3;

      if (cfg.shape == SHAPE_LINEAR) begin
        fx <= FORCE_W'($signed(cfg.linear_x));
        fy <= FORCE_W'($signed(cfg.linear_y));
      end else begin
        fx <= fxs[FORCE_W-1:0];
        fy <= fys[FORCE_W-1:0];
      end
      side_o <= side4;
    end
  end

  assign out_vld = vld[4];

endmodule

@@ rtl/particle_force_field_eval.sv @@
// top level of the particle force field evaluator: register file, front
// stages, square root, dividers, shape stages and result register
// depends on pffe_pkg, pffe_sqrt_pipe, pffe_div_pipe and pffe_shape
//
//  port group   | kind                 | handshake
//  -------------+----------------------+----------------------------------
//  request      | pos, mass, sums      | req_valid / req_stall
//  result       | new_acc, new_off     | rsp_valid / rsp_stall
//  config       | APB-style registers  | psel, penable, pwrite, pready
//
// one request enters per cycle while not stalled; each result passes
// the 33 square root stages and two 32-stage divider chains in series
// reset clears the valid bits and loads the register defaults
// a stalled result freezes the whole pipeline and req_stall rises with it
module particle_force_field_eval
  import pffe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic signed [DATA_W-1:0] pos_x,
  input  logic signed [DATA_W-1:0] pos_y,
  input  logic [MAG_W-1:0]         mass,
  input  logic signed [DATA_W-1:0] acc_x,
  input  logic signed [DATA_W-1:0] acc_y,
  input  logic signed [DATA_W-1:0] off_x,
  input  logic signed [DATA_W-1:0] off_y,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic signed [DATA_W-1:0] new_acc_x,
  output logic signed [DATA_W-1:0] new_acc_y,
  output logic signed [DATA_W-1:0] new_off_x,
  output logic signed [DATA_W-1:0] new_off_y
);

  typedef struct packed {
    logic [MAG_W-1:0]  mass;
    logic [DATA_W-1:0] acc_x;
    logic [DATA_W-1:0] acc_y;
    logic [DATA_W-1:0] off_x;
    logic [DATA_W-1:0] off_y;
  } base_t;

  typedef struct packed {
    logic              neg_x;
    logic              neg_y;
    logic [DATA_W-1:0] mdx;
    logic [DATA_W-1:0] mdy;
    base_t             base;
  } sq_side_t;

  typedef struct packed {
    logic  neg_x;
    logic  neg_y;
    logic  d_zero;
    base_t base;
  } div_side_t;

  typedef struct packed {
    logic [FORCE_W-1:0] fx;
    logic [FORCE_W-1:0] fy;
    base_t              base;
  } mdiv_side_t;

  // configuration registers
  shape_t                   shape;
  force_type_t              force_type;
  logic signed [DATA_W-1:0] origin_x;
  logic signed [DATA_W-1:0] origin_y;
  logic [MAG_W-1:0]         radius;
  logic signed [DATA_W-1:0] pull;
  logic signed [DATA_W-1:0] linear_x;
  logic signed [DATA_W-1:0] linear_y;

  logic       en;
  logic       cfg_wr;
  reg_idx_t   reg_idx;
  shape_cfg_t shape_cfg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      shape      <= SHAPE_LINEAR;
      force_type <= FT_GRAVITY;
      origin_x   <= '0;
      origin_y   <= '0;
      radius     <= '0;
      pull       <= '0;
      linear_x   <= '0;
      linear_y   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SHAPE:      shape      <= shape_t'(pwdata[1:0]);
        REG_FORCE_TYPE: force_type <= force_type_t'(pwdata[1:0]);
        REG_ORIGIN_X:   origin_x   <= pwdata;
        REG_ORIGIN_Y:   origin_y   <= pwdata;
        REG_RADIUS:     radius     <= pwdata[MAG_W-1:0];
        REG_PULL:       pull       <= pwdata;
        REG_LINEAR_X:   linear_x   <= pwdata;
        REG_LINEAR_Y:   linear_y   <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SHAPE:      prdata = DATA_W'(shape);
      REG_FORCE_TYPE: prdata = DATA_W'(force_type);
      REG_ORIGIN_X:   prdata = origin_x;
      REG_ORIGIN_Y:   prdata = origin_y;
      REG_RADIUS:     prdata = DATA_W'(radius);
      REG_PULL:       prdata = pull;
      REG_LINEAR_X:   prdata = linear_x;
      REG_LINEAR_Y:   prdata = linear_y;
    endcase
  end

  assign shape_cfg = '{shape: shape, pull: pull, linear_x: linear_x, linear_y: linear_y};

  assign en        = !rsp_valid || !rsp_stall;
  assign req_stall = !en;

  // front: offset from the emitter, squares, sum of squares
  logic                     v1, v2, v3;
  logic signed [DIFF_W-1:0] dx1, dy1;
  base_t                    base1;
  logic [63:0]              a2, b2;
  sq_side_t                 sq2, sq3;
  logic [SQ_W-1:0]          sum3;
  logic [DIFF_W-1:0]        adx, ady;

  assign adx = dx1[DIFF_W-1] ? DIFF_W'(-dx1) : DIFF_W'(dx1);
  assign ady = dy1[DIFF_W-1] ? DIFF_W'(-dy1) : DIFF_W'(dy1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1   <= DIFF_W'(origin_x) - DIFF_W'(pos_x);
      dy1   <= DIFF_W'(origin_y) - DIFF_W'(pos_y);
      base1 <= '{mass: mass, acc_x: acc_x, acc_y: acc_y, off_x: off_x, off_y: off_y};

      a2  <= 64'(adx[DATA_W-1:0]) * 64'(adx[DATA_W-1:0]);
      b2  <= 64'(ady[DATA_W-1:0]) * 64'(ady[DATA_W-1:0]);
      sq2 <= '{neg_x: dx1[DIFF_W-1], neg_y: dy1[DIFF_W-1],
               mdx: adx[DATA_W-1:0], mdy: ady[DATA_W-1:0], base: base1};

      sum3 <= SQ_W'(a2) + SQ_W'(b2);
      sq3  <= sq2;
    end
  end

  // distance
  logic              v_sq;
  logic [ROOT_W-1:0] d_root;
  sq_side_t          sq_o;

  pffe_sqrt_pipe #(
    .SIDE_W ($bits(sq_side_t))
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v3),
    .rad     (sum3),
    .side    (sq3),
    .out_vld (v_sq),
    .root    (d_root),
    .side_o  (sq_o)
  );

  // unit vector and normalized distance, three dividers side by side
  div_side_t        dside_i, dside_o;
  logic             v_div;
  logic [QUO_W-1:0] uxq, uyq, tq;
  logic             uxo, uyo, to;

  assign dside_i = '{neg_x: sq_o.neg_x, neg_y: sq_o.neg_y,
                     d_zero: (d_root == '0), base: sq_o.base};

  pffe_div_pipe #(
    .NUM_W  (DATA_W + FRAC_W),
    .DEN_W  (ROOT_W),
    .Q_W    (QUO_W),
    .SIDE_W ($bits(div_side_t))
  ) u_div_ux (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v_sq),
    .num     ({sq_o.mdx, FRAC_W'(0)}),
    .den     (d_root),
    .side    (dside_i),
    .out_vld (v_div),
    .quo     (uxq),
    .ovf     (uxo),
    .side_o  (dside_o)
  );

  pffe_div_pipe #(
    .NUM_W  (DATA_W + FRAC_W),
    .DEN_W  (ROOT_W),
    .Q_W    (QUO_W),
    .SIDE_W (1)
  ) u_div_uy (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v_sq),
    .num     ({sq_o.mdy, FRAC_W'(0)}),
    .den     (d_root),
    .side    (1'b0),
    .out_vld (),
    .quo     (uyq),
    .ovf     (uyo),
    .side_o  ()
  );

  pffe_div_pipe #(
    .NUM_W  (ROOT_W + FRAC_W),
    .DEN_W  (MAG_W),
    .Q_W    (QUO_W),
    .SIDE_W (1)
  ) u_div_t (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v_sq),
    .num     ({d_root, FRAC_W'(0)}),
    .den     (radius),
    .side    (1'b0),
    .out_vld (),
    .quo     (tq),
    .ovf     (to),
    .side_o  ()
  );

  // unit components never exceed one, so the low 17 quotient bits hold them
  logic                     v5;
  logic signed [UNIT_W-1:0] ux5, uy5;
  logic [QUO_W-1:0]         t5;
  base_t                    base5;
  logic signed [UNIT_W-1:0] uxm, uym;

  assign uxm = $signed({1'b0, uxq[16:0]});
  assign uym = $signed({1'b0, uyq[16:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v_div;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dside_o.d_zero || uxo) begin
        ux5 <= '0;
      end else begin
        ux5 <= dside_o.neg_x ? -uxm : uxm;
      end
      if (dside_o.d_zero || uyo) begin
        uy5 <= '0;
      end else begin
        uy5 <= dside_o.neg_y ? -uym : uym;
      end
      t5    <= to ? QUO_W'(I32_MAX) : tq;
      base5 <= dside_o.base;
    end
  end

  // force vector
  logic                      v_f;
  logic signed [FORCE_W-1:0] fx, fy;
  base_t                     base_f;

  pffe_shape #(
    .SIDE_W ($bits(base_t))
  ) u_shape (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v5),
    .ux      (ux5),
    .uy      (uy5),
    .t       (t5),
    .cfg     (shape_cfg),
    .side    (base5),
    .out_vld (v_f),
    .fx      (fx),
    .fy      (fy),
    .side_o  (base_f)
  );

  // force over mass
  logic [FORCE_W-1:0] afx, afy;
  mdiv_side_t         mside_i, mside_o;
  logic               v_m;
  logic [QUO_W-1:0]   mqx, mqy;
  logic               mox, moy;

  assign afx     = fx[FORCE_W-1] ? FORCE_W'(-fx) : FORCE_W'(fx);
  assign afy     = fy[FORCE_W-1] ? FORCE_W'(-fy) : FORCE_W'(fy);
  assign mside_i = '{fx: fx, fy: fy, base: base_f};

  pffe_div_pipe #(
    .NUM_W  (DATA_W + FRAC_W),
    .DEN_W  (MAG_W),
    .Q_W    (QUO_W),
    .SIDE_W ($bits(mdiv_side_t))
  ) u_div_mx (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v_f),
    .num     ({afx[DATA_W-1:0], FRAC_W'(0)}),
    .den     (base_f.mass),
    .side    (mside_i),
    .out_vld (v_m),
    .quo     (mqx),
    .ovf     (mox),
    .side_o  (mside_o)
  );

  pffe_div_pipe #(
    .NUM_W  (DATA_W + FRAC_W),
    .DEN_W  (MAG_W),
    .Q_W    (QUO_W),
    .SIDE_W (1)
  ) u_div_my (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v_f),
    .num     ({afy[DATA_W-1:0], FRAC_W'(0)}),
    .den     (base_f.mass),
    .side    (1'b0),
    .out_vld (),
    .quo     (mqy),
    .ovf     (moy),
    .side_o  ()
  );

  // quotient saturates to the int32 limits by the sign of the force
  logic signed [FORCE_W-1:0] qx, qy;
  logic signed [FORCE_W-1:0] mfx, mfy;

  assign mfx = $signed(mside_o.fx);
  assign mfy = $signed(mside_o.fy);

  always_comb begin
    if (mfx == '0) begin
      qx = '0;
    end else if (mfx > 0) begin
      qx = mox ? FORCE_W'(I32_MAX) : $signed(FORCE_W'(mqx));
    end else begin
      qx = mox ? FORCE_W'(I32_MIN) : -$signed(FORCE_W'(mqx));
    end
    if (mfy == '0) begin
      qy = '0;
    end else if (mfy > 0) begin
      qy = moy ? FORCE_W'(I32_MAX) : $signed(FORCE_W'(mqy));
    end else begin
      qy = moy ? FORCE_W'(I32_MIN) : -$signed(FORCE_W'(mqy));
    end
  end

  logic signed [DATA_W-1:0] ax_c, ay_c, ox_c, oy_c;

  always_comb begin
    ax_c = $signed(mside_o.base.acc_x);
    ay_c = $signed(mside_o.base.acc_y);
    ox_c = $signed(mside_o.base.off_x);
    oy_c = $signed(mside_o.base.off_y);
    case (force_type)
      FT_FORCE: begin
        ax_c = sat32(48'($signed(mside_o.base.acc_x)) + 48'(qx));
        ay_c = sat32(48'($signed(mside_o.base.acc_y)) + 48'(qy));
      end
      FT_GRAVITY: begin
        ax_c = sat32(48'($signed(mside_o.base.acc_x)) + 48'(mfx));
        ay_c = sat32(48'($signed(mside_o.base.acc_y)) + 48'(mfy));
      end
      FT_OFFSET: begin
        ox_c = sat32(48'($signed(mside_o.base.off_x)) + 48'(mfx));
        oy_c = sat32(48'($signed(mside_o.base.off_y)) + 48'(mfy));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= v_m;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_acc_x <= ax_c;
      new_acc_y <= ay_c;
      new_off_x <= ox_c;
      new_off_y <= oy_c;
    end
  end

  // pipeline only holds while a finished result is refused
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (rsp_valid && rsp_stall))
    else $error("request stalled without a refused result");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  // undefined force type leaves both sums untouched
  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (en && v_m && force_type != FT_FORCE && force_type != FT_GRAVITY &&
     force_type != FT_OFFSET)
    |=> (new_acc_x == $past(mside_o.base.acc_x) && new_off_y == $past(mside_o.base.off_y)))
    else $error("sums changed for an undefined force type");

endmodule

@@ bench/particle_force_field_eval_tb.sv @@
// self-checking bench for the particle force field evaluator: a queue-fed driver,
// a result monitor and a fixed-point predictor built from the block's rules
// depends on pffe_pkg and particle_force_field_eval
`timescale 1ns / 100ps

module particle_force_field_eval_tb;
  import pffe_pkg::*;

  typedef struct {
    logic signed [31:0] px, py;
    logic [30:0]        m;
    logic signed [31:0] ax, ay, ox, oy;
  } particle_t;

  typedef struct {
    logic signed [31:0] acc_x, acc_y, off_x, off_y;
  } sums_t;

  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;
  localparam int DRAIN = 150;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0, rst = 1'b1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
  logic signed [31:0] pos_x = 0, pos_y = 0, acc_x = 0, acc_y = 0, off_x = 0, off_y = 0;
  logic [30:0] mass = 0;
  logic signed [31:0] new_acc_x, new_acc_y, new_off_x, new_off_y;

  particle_force_field_eval dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // emitter settings as the block should hold them
  shape_t             em_shape = SHAPE_LINEAR;
  logic [1:0]         em_type = FT_GRAVITY;
  logic signed [31:0] em_ox = 0, em_oy = 0, em_pull = 0, em_lx = 0, em_ly = 0;
  logic [30:0]        em_radius = 0;

  particle_t pending_particles[$];
  sums_t     expected_sums[$];
  int errors = 0, accepted = 0, results_seen = 0;
  bit req_took = 0, idle_on = 1, sender_hold = 0, long_hold = 0;
  int send_gap = 0, recv_gap = 0, hold_left = 0, quiet_cycles = 0;

  function automatic longint sat(longint v);
    return v > MAXV ? MAXV : (v < MINV ? MINV : v);
  endfunction

  // Q16.16 product, floored
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  // trunc(num * 2^16 / den), saturated; zero den saturates by sign
  function automatic longint qdiv(longint num, longint unsigned den);
    longint unsigned m;
    longint q;
    if (den == 0) return num > 0 ? MAXV : (num < 0 ? MINV : 0);
    m = num < 0 ? -num : num;
    m = (m << 16) / den;
    if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
    q = m;
    return sat(num < 0 ? -q : q);
  endfunction

  function automatic longint floor_sqrt(logic [65:0] v);
    logic [39:0] root, rem, trial;
    root = 0;
    rem = 0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | v[2*i +: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic sums_t apply_emitter(particle_t p);
    sums_t r;
    longint dx, dy, d, ux, uy, t, s, fx, fy, ax, ay, ox, oy;
    logic [32:0] mx, my;
    dx = longint'(em_ox) - longint'(p.px);
    dy = longint'(em_oy) - longint'(p.py);
    mx = 33'(dx < 0 ? -dx : dx);
    my = 33'(dy < 0 ? -dy : dy);
    d = floor_sqrt(66'(mx) * 66'(mx) + 66'(my) * 66'(my));
    ux = 0; uy = 0; fx = 0; fy = 0;
    if (d != 0) begin
      ux = qdiv(dx, d);
      uy = qdiv(dy, d);
    end
    t = em_radius == 0 ? MAXV : qdiv(d, em_radius);
    case (em_shape)
      SHAPE_ATTRACTOR: if (t <= 65536) begin
        s = qmul(qmul(65536 - t, 65536 - t), em_pull);
        fx = qmul(ux, s);
        fy = qmul(uy, s);
      end
      SHAPE_BASIN: begin
        s = sat(qmul(sat(qmul(t, t)), em_pull));
        fx = qmul(ux, s);
        fy = qmul(uy, s);
      end
      SHAPE_LINEAR: begin
        fx = em_lx;
        fy = em_ly;
      end
      default: begin
        fx = qmul(ux, em_pull);
        fy = qmul(uy, em_pull);
      end
    endcase
    ax = p.ax; ay = p.ay; ox = p.ox; oy = p.oy;
    case (em_type)
      FT_FORCE: begin
        ax = sat(ax + qdiv(fx, p.m));
        ay = sat(ay + qdiv(fy, p.m));
      end
      FT_GRAVITY: begin
        ax = sat(ax + fx);
        ay = sat(ay + fy);
      end
      FT_OFFSET: begin
        ox = sat(ox + fx);
        oy = sat(oy + fy);
      end
      default: ;
    endcase
    r.acc_x = ax[31:0]; r.acc_y = ay[31:0]; r.off_x = ox[31:0]; r.off_y = oy[31:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 19);
    if (k < 14) return 0;
    if (k < 19) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] any32();
    case ($urandom_range(0, 4))
      0: case ($urandom_range(0, 4))
           0: return 32'h7fffffff;
           1: return 32'h80000000;
           2: return 32'h0;
           3: return 32'hffffffff;
           default: return 32'h1;
         endcase
      1, 2: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic particle_t random_particle();
    particle_t p;
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      p.px = em_ox;
      p.py = em_oy;
    end else if (k < 6) begin
      // near the emitter so the radius shapes come into play
      p.px = em_ox + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      p.py = em_oy + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    end else begin
      p.px = any32();
      p.py = any32();
    end
    case ($urandom_range(0, 5))
      0: p.m = 0;
      1: p.m = 31'h7fffffff;
      2: p.m = 31'($urandom);
      default: p.m = 31'($urandom_range(1, 1 << 20));
    endcase
    p.ax = any32(); p.ay = any32(); p.ox = any32(); p.oy = any32();
    return p;
  endfunction

  function automatic particle_t make_particle(logic [31:0] x, logic [31:0] y, logic [30:0] m,
                                              logic [31:0] s);
    particle_t p;
    p.px = x; p.py = y; p.m = m; p.ax = s; p.ay = ~s; p.ox = s; p.oy = ~s;
    return p;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, want %h (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_SHAPE:      em_shape = shape_t'(val[1:0]);
      REG_FORCE_TYPE: em_type = val[1:0];
      REG_ORIGIN_X:   em_ox = val;
      REG_ORIGIN_Y:   em_oy = val;
      REG_RADIUS:     em_radius = val[30:0];
      REG_PULL:       em_pull = val;
      REG_LINEAR_X:   em_lx = val;
      default:        em_ly = val;
    endcase
  endtask

  // checked at clock edges so a request being handed over is never missed
  task automatic wait_idle();
    while (pending_particles.size() != 0 || req_valid || expected_sums.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // sample both handshakes, predict and check
  always @(posedge clk) begin
    req_took <= req_valid && !req_stall && !rst;
    if (!rst && req_valid && !req_stall) begin
      expected_sums.push_back(apply_emitter('{pos_x, pos_y, mass, acc_x, acc_y, off_x, off_y}));
      accepted++;
    end
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (expected_sums.size() == 0) begin
        $display("unexpected result %0d", results_seen);
        errors++;
      end else begin
        sums_t e;
        e = expected_sums.pop_front();
        if (new_acc_x !== e.acc_x) report("new_acc_x", new_acc_x, e.acc_x);
        if (new_acc_y !== e.acc_y) report("new_acc_y", new_acc_y, e.acc_y);
        if (new_off_x !== e.off_x) report("new_off_x", new_off_x, e.off_x);
        if (new_off_y !== e.off_y) report("new_off_y", new_off_y, e.off_y);
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 0;
      end else if (pending_particles.size() > 0 && !sender_hold) begin
        particle_t p;
        p = pending_particles.pop_front();
        pos_x <= p.px; pos_y <= p.py; mass <= p.m;
        acc_x <= p.ax; acc_y <= p.ay; off_x <= p.ox; off_y <= p.oy;
        req_valid <= 1;
        send_gap = idle_on ? pick_gap() : 0;
      end else begin
        req_valid <= 0;
      end
    end
  end

  // result stall, with one long hold on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1;
    end else if (long_hold) begin
      long_hold = 0;
      hold_left = 400;
      rsp_stall <= 1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      rsp_stall <= 1;
    end else begin
      rsp_stall <= 0;
      if (idle_on && $urandom_range(0, 5) == 0) recv_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;

    // reset defaults: linear gravity with zero vector passes sums through
    for (int i = 0; i < 4; i++) pending_particles.push_back(random_particle());
    wait_idle();

    write_reg(REG_SHAPE, SHAPE_ATTRACTOR);
    write_reg(REG_FORCE_TYPE, FT_FORCE);
    write_reg(REG_RADIUS, 32'h000a0000);
    write_reg(REG_PULL, 32'h00020000);
    pending_particles.push_back(make_particle(0, 0, 31'h10000, 0));          // coincident
    pending_particles.push_back(make_particle(32'h00010000, 0, 0, 0));       // zero mass
    pending_particles.push_back(make_particle(32'hffff0000, 0, 0, 0));
    pending_particles.push_back(make_particle(32'h00030000, 32'h00040000, 31'h8000, 32'h7fffffff));
    pending_particles.push_back(make_particle(32'h7fffffff, 32'h80000000, 31'h7fffffff, 32'h80000000));
    pending_particles.push_back(make_particle(32'h80000000, 32'h7fffffff, 1, 32'h7fffffff));
    pending_particles.push_back(make_particle(32'h00050000, 0, 1, 32'h7ffffff0));
    pending_particles.push_back(make_particle(32'h000a0000, 0, 31'h10000, 0)); // on the rim
    pending_particles.push_back(make_particle(32'hfff60000, 0, 31'h10000, 0));
    pending_particles.push_back(make_particle(32'hffffffff, 32'h00000001, 31'h10000, 0));
    wait_idle();
    write_reg(REG_SHAPE, SHAPE_BASIN);
    write_reg(REG_RADIUS, 0);                                                // zero radius
    write_reg(REG_FORCE_TYPE, FT_OFFSET);
    write_reg(REG_PULL, 32'h7fffffff);
    write_reg(REG_LINEAR_X, 32'h80000000);
    write_reg(REG_LINEAR_Y, 32'h7fffffff);
    pending_particles.push_back(make_particle(0, 0, 31'h10000, 0));
    pending_particles.push_back(make_particle(32'h00010000, 32'h00010000, 31'h10000, 32'h7fffffff));
    pending_particles.push_back(make_particle(32'h80000000, 32'h80000000, 0, 32'h80000000));
    pending_particles.push_back(make_particle(32'h7fffffff, 0, 0, 32'h12345678));
    wait_idle();
    write_reg(REG_SHAPE, SHAPE_LINEAR);
    write_reg(REG_FORCE_TYPE, 2'd3);                                         // undefined type
    for (int i = 0; i < 4; i++) pending_particles.push_back(random_particle());
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_SHAPE, shape_t'(ph % 4));
      write_reg(REG_FORCE_TYPE, (ph / 4) % 3);
      write_reg(REG_ORIGIN_X, ph == 5 ? 32'h7fffffff : (ph == 6 ? 32'h80000000 : any32()));
      write_reg(REG_ORIGIN_Y, ph == 5 ? 32'h80000000 : (ph == 6 ? 32'h7fffffff : any32()));
      case (ph % 3)
        0: write_reg(REG_RADIUS, $urandom_range(1 << 16, 1 << 22));
        1: write_reg(REG_RADIUS, ph == 4 ? 32'h7fffffff : 32'($urandom) >> 1);
        default: write_reg(REG_RADIUS, ph == 8 ? 0 : $urandom_range(1, 1 << 21));
      endcase
      write_reg(REG_PULL, ph == 7 ? 32'h80000000 : (ph == 3 ? 32'h7fffffff : any32()));
      write_reg(REG_LINEAR_X, any32());
      write_reg(REG_LINEAR_Y, any32());
      idle_on = (ph % 4) != 2;
      if (ph == 3) begin
        // receiver holds off long while the sender keeps offering
        long_hold = 1;
      end
      for (int i = 0; i < 78; i++) pending_particles.push_back(random_particle());
      if (ph == 9) begin
        // pause the sender midway until the pipe drains
        wait (pending_particles.size() < 40);
        sender_hold = 1;
        while (req_valid || expected_sums.size() != 0) @(posedge clk);
        sender_hold = 0;
      end
      wait_idle();
    end

    $display("covered %0d requests and %0d results over all shapes and force types,",
             accepted, results_seen);
    $display("including zero mass, zero radius, coincident points and saturating sums");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
